// File: design/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants for the sequential turn arrow pixel
// Segment geometry, register codes, transaction payloads and the
// per-position distance tables used by the pixel pipeline.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Segment geometry
  localparam int MAIN_HEIGHT  = 8;
  localparam int MAIN_WIDTH   = 16;
  localparam int STRIP_HEIGHT = 4;
  localparam int STRIP_WIDTH  = 16;

  localparam int MAIN_H_M1  = MAIN_HEIGHT - 1;
  localparam int MAIN_W_M1  = MAIN_WIDTH - 1;
  localparam int STRIP_H_M1 = STRIP_HEIGHT - 1;
  localparam int STRIP_W_M1 = STRIP_WIDTH - 1;

  // Field widths
  localparam int SEG_W      = 2;
  localparam int POS_W      = 6;
  localparam int LUT_DEPTH  = 2 ** POS_W;
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 11;
  localparam int HALF_W     = PERIOD_W - 1;
  localparam int COLOUR_W   = 24;
  localparam int CHAN_W     = 8;
  localparam int TRAVEL_W   = 8;
  localparam int WING_W     = 6;
  localparam int REACH_W    = 9;
  localparam int PROD_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COLOUR_W;

  // Blink timing
  localparam int PERIOD_MIN   = 200;
  localparam int PERIOD_MAX   = 1500;
  localparam int PERIOD_RESET = 700;
  localparam int FRONT_SPAN   = 400;
  localparam int TRAVEL_SPAN  = 255;
  localparam int WING_SPAN    = 40;

  localparam logic [COLOUR_W-1:0] TURN_RESET  = 24'hFF8000;
  localparam logic [COLOUR_W-1:0] BRAKE_RESET = 24'hFF0000;

  // Remainder unit: dividend bits retired per pipeline stage
  localparam int MOD_BITS_PER_STAGE = 4;
  localparam int MOD_STAGES         = TIME_W / MOD_BITS_PER_STAGE;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_COLOUR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_COLOUR = 2'd2;

  // Opcodes and segment codes
  localparam logic OPC_START = 1'b0;
  localparam logic OPC_PIXEL = 1'b1;

  localparam logic [SEG_W-1:0] SEG_PANEL  = 2'd0;
  localparam logic [SEG_W-1:0] SEG_TOP    = 2'd1;
  localparam logic [SEG_W-1:0] SEG_BOTTOM = 2'd2;

  // Transaction payloads
  typedef struct packed {
    logic              opcode;
    logic [SEG_W-1:0]  segment;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [TIME_W-1:0] now_ms;
    logic              braking;
  } pix_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] blink_period_ms;
    logic [COLOUR_W-1:0] turn_colour;
    logic [COLOUR_W-1:0] brake_colour;
  } cfg_t;

  // What a pixel resolves to before the blink phase is known
  typedef enum logic [1:0] {
    PIX_BLACK,
    PIX_BRAKE,
    PIX_SWEEP
  } pix_kind_e;

  typedef struct packed {
    pix_kind_e          kind;
    logic [REACH_W-1:0] reach;
  } pix_tag_t;

  typedef struct packed {
    pix_tag_t          tag;
    logic [TIME_W-1:0] elapsed;
  } entry_t;

  typedef struct packed {
    pix_tag_t            tag;
    logic [PERIOD_W-1:0] phase;
  } phase_t;

  // Distance tables, indexed by column (travel) or row (wing)
  typedef logic [LUT_DEPTH-1:0][TRAVEL_W-1:0] travel_lut_t;
  typedef logic [LUT_DEPTH-1:0][WING_W-1:0]   wing_lut_t;

  function automatic travel_lut_t main_travel_lut();
    travel_lut_t t;
    t = '0;
    for (int i = 0; i < MAIN_WIDTH; i++) begin
      t[i] = TRAVEL_W'((MAIN_W_M1 - i) * TRAVEL_SPAN / MAIN_W_M1);
    end
    return t;
  endfunction

  function automatic travel_lut_t strip_travel_lut();
    travel_lut_t t;
    t = '0;
    for (int i = 0; i < STRIP_WIDTH; i++) begin
      t[i] = TRAVEL_W'((STRIP_W_M1 - i) * TRAVEL_SPAN / STRIP_W_M1);
    end
    return t;
  endfunction

  function automatic wing_lut_t main_wing_lut();
    wing_lut_t t;
    int        dr;
    t = '0;
    for (int i = 0; i < MAIN_HEIGHT; i++) begin
      dr = 2 * i - MAIN_H_M1;
      if (dr < 0) dr = -dr;
      t[i] = WING_W'(dr * WING_SPAN / MAIN_H_M1);
    end
    return t;
  endfunction

  function automatic wing_lut_t strip_wing_lut();
    wing_lut_t t;
    int        dr;
    t = '0;
    for (int i = 0; i < STRIP_HEIGHT; i++) begin
      dr = 2 * i - STRIP_H_M1;
      if (dr < 0) dr = -dr;
      t[i] = WING_W'(dr * WING_SPAN / STRIP_H_M1);
    end
    return t;
  endfunction

  localparam travel_lut_t MAIN_TRAVEL  = main_travel_lut();
  localparam travel_lut_t STRIP_TRAVEL = strip_travel_lut();
  localparam wing_lut_t   MAIN_WING    = main_wing_lut();
  localparam wing_lut_t   STRIP_WING   = strip_wing_lut();

endpackage

// File: design/stp_pix_if.sv
// ----------------------------------------------------------------------------
// stp_pix_if: pixel request channel
// Valid/ready stream carrying one start or pixel request per transaction.
// ----------------------------------------------------------------------------
interface stp_pix_if import stp_pkg::*; ();
  logic     valid;
  logic     ready;
  pix_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/stp_rgb_if.sv
// ----------------------------------------------------------------------------
// stp_rgb_if: pixel color channel
// Valid/ready stream carrying one RGB result per transaction.
// ----------------------------------------------------------------------------
interface stp_rgb_if import stp_pkg::*; ();
  logic valid;
  logic ready;
  rgb_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/stp_cfg.sv
// ----------------------------------------------------------------------------
// stp_cfg: configuration registers
// Blink period (saturated on write), turn color and brake color.
// ----------------------------------------------------------------------------
module stp_cfg import stp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t                cfg_q;
  logic [PERIOD_W-1:0] period_sat;

  // Clamp written period into the legal blink range
  always_comb begin
    period_sat = cfg_data_i[PERIOD_W-1:0];
    if (period_sat < PERIOD_W'(PERIOD_MIN)) period_sat = PERIOD_W'(PERIOD_MIN);
    if (period_sat > PERIOD_W'(PERIOD_MAX)) period_sat = PERIOD_W'(PERIOD_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_period_ms <= PERIOD_W'(PERIOD_RESET);
      cfg_q.turn_colour     <= TURN_RESET;
      cfg_q.brake_colour    <= BRAKE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLINK_PERIOD: cfg_q.blink_period_ms <= period_sat;
        REG_TURN_COLOUR:  cfg_q.turn_colour     <= cfg_data_i[COLOUR_W-1:0];
        REG_BRAKE_COLOUR: cfg_q.brake_colour    <= cfg_data_i[COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/stp_entry.sv
// ----------------------------------------------------------------------------
// stp_entry: request decode stage
// Records the start time, classifies the pixel, looks up its travel and
// wing distances and forms the elapsed time for the remainder unit.
// ----------------------------------------------------------------------------
module stp_entry import stp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output entry_t   out_data_o
);

  logic [TIME_W-1:0]   start_q;
  logic                vld_q;
  entry_t              data_q;
  logic                accept;
  logic                is_pixel;
  logic                pos_ok;
  logic [TRAVEL_W-1:0] travel;
  logic [WING_W-1:0]   wing;
  pix_tag_t            tag_d;

  assign in_ready_o = !vld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (in_data_i.opcode == OPC_PIXEL);

  // Segment bounds and distance lookup
  always_comb begin
    pos_ok = 1'b0;
    travel = '0;
    wing   = '0;
    case (in_data_i.segment)
      SEG_PANEL: begin
        pos_ok = ({1'b0, in_data_i.row} < (POS_W + 1)'(MAIN_HEIGHT)) &&
                 ({1'b0, in_data_i.col} < (POS_W + 1)'(MAIN_WIDTH));
        travel = MAIN_TRAVEL[in_data_i.col];
        wing   = MAIN_WING[in_data_i.row];
      end
      SEG_TOP, SEG_BOTTOM: begin
        pos_ok = ({1'b0, in_data_i.row} < (POS_W + 1)'(STRIP_HEIGHT)) &&
                 ({1'b0, in_data_i.col} < (POS_W + 1)'(STRIP_WIDTH));
        travel = STRIP_TRAVEL[in_data_i.col];
        wing   = STRIP_WING[in_data_i.row];
      end
      default: pos_ok = 1'b0;
    endcase
  end

  // Pixel class: black off-panel, solid brake, or swept
  always_comb begin
    tag_d.reach = REACH_W'(travel) + REACH_W'(wing);
    if (!pos_ok) begin
      tag_d.kind = PIX_BLACK;
    end else if (in_data_i.braking && (in_data_i.segment != SEG_TOP)) begin
      tag_d.kind = PIX_BRAKE;
    end else begin
      tag_d.kind = PIX_SWEEP;
    end
  end

  // Control: start requests end here and leave a bubble
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      start_q <= '0;
    end else begin
      if (accept && !is_pixel) start_q <= in_data_i.now_ms;
      if (in_ready_o) vld_q <= accept && is_pixel;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept && is_pixel) begin
      data_q.tag     <= tag_d;
      data_q.elapsed <= in_data_i.now_ms - start_q;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

// File: design/stp_mod.sv
// ----------------------------------------------------------------------------
// stp_mod: pipelined remainder unit
// Elapsed time modulo the blink period, restoring style, a few dividend
// bits per stage. Each stage advances on its own so bubbles collapse.
// ----------------------------------------------------------------------------
module stp_mod import stp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [PERIOD_W-1:0] period_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  entry_t              in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phase_t              out_data_o
);

  logic                vld_q [MOD_STAGES];
  logic [PERIOD_W-1:0] rem_q [MOD_STAGES];
  logic [TIME_W-1:0]   dvd_q [MOD_STAGES];
  pix_tag_t            tag_q [MOD_STAGES];
  logic [MOD_STAGES:0] rdy;

  // Retire a group of dividend bits into the partial remainder
  function automatic logic [PERIOD_W-1:0] mod_step(
    input logic [PERIOD_W-1:0]           rem,
    input logic [MOD_BITS_PER_STAGE-1:0] bits,
    input logic [PERIOD_W-1:0]           per
  );
    logic [PERIOD_W:0]   acc;
    logic [PERIOD_W-1:0] r;
    r = rem;
    for (int b = MOD_BITS_PER_STAGE - 1; b >= 0; b--) begin
      acc = {r, bits[b]};
      if (acc >= {1'b0, per}) acc = acc - {1'b0, per};
      r = acc[PERIOD_W-1:0];
    end
    return r;
  endfunction

  // A stage may load when it is empty or its successor moves
  always_comb begin
    rdy[MOD_STAGES] = out_ready_i;
    for (int s = MOD_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
    logic                src_vld;
    logic [PERIOD_W-1:0] src_rem;
    logic [TIME_W-1:0]   src_dvd;
    pix_tag_t            src_tag;

    if (s == 0) begin : g_first
      assign src_vld = in_valid_i;
      assign src_rem = '0;
      assign src_dvd = in_data_i.elapsed;
      assign src_tag = in_data_i.tag;
    end else begin : g_next
      assign src_vld = vld_q[s-1];
      assign src_rem = rem_q[s-1];
      assign src_dvd = dvd_q[s-1];
      assign src_tag = tag_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_vld) begin
        rem_q[s] <= mod_step(src_rem, src_dvd[TIME_W-1 -: MOD_BITS_PER_STAGE], period_i);
        dvd_q[s] <= src_dvd << MOD_BITS_PER_STAGE;
        tag_q[s] <= src_tag;
      end
    end
  end

  assign out_valid_o      = vld_q[MOD_STAGES-1];
  assign out_data_o.tag   = tag_q[MOD_STAGES-1];
  assign out_data_o.phase = rem_q[MOD_STAGES-1];

endmodule

// File: design/stp_shade.sv
// ----------------------------------------------------------------------------
// stp_shade: sweep test and color select
// Stage A scales distance and phase so the sweep front needs no divide;
// stage B compares and registers the final color.
// ----------------------------------------------------------------------------
module stp_shade import stp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  phase_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output rgb_t   out_data_o
);

  logic              a_vld_q;
  pix_kind_e         a_kind_q;
  logic              a_first_q;
  logic [PROD_W-1:0] a_lhs_q;
  logic [PROD_W-1:0] a_rhs_q;
  logic              b_vld_q;
  rgb_t              b_rgb_q;
  logic              rdy_a;
  logic              rdy_b;
  logic [HALF_W-1:0] half;
  logic [COLOUR_W-1:0] colour;

  assign half       = cfg_i.blink_period_ms[PERIOD_W-1:1];
  assign rdy_b      = !b_vld_q || out_ready_i;
  assign rdy_a      = !a_vld_q || rdy_b;
  assign in_ready_o = rdy_a;

  // front >= reach  <=>  phase * FRONT_SPAN >= reach * half
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (rdy_a) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      a_kind_q  <= in_data_i.tag.kind;
      a_first_q <= in_data_i.phase < PERIOD_W'(half);
      a_lhs_q   <= PROD_W'(in_data_i.tag.reach) * PROD_W'(half);
      a_rhs_q   <= PROD_W'(in_data_i.phase) * PROD_W'(FRONT_SPAN);
    end
  end

  // Color select
  always_comb begin
    case (a_kind_q)
      PIX_SWEEP: colour = (a_first_q && (a_lhs_q <= a_rhs_q)) ? cfg_i.turn_colour : '0;
      PIX_BRAKE: colour = cfg_i.brake_colour;
      default:   colour = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (rdy_b) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_vld_q) begin
      b_rgb_q <= rgb_t'(colour);
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_data_o  = b_rgb_q;

endmodule

// File: design/sequential_turn_arrow_pixel_top.sv
// ----------------------------------------------------------------------------
// sequential_turn_arrow_pixel_top: sequential turn arrow pixel generator
// Takes one request per cycle unless stalled; returns each pixel's RGB color.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries requests. Opcode start latches now_ms as the animation
//   start and returns nothing; opcode pixel returns exactly one color on
//   rgb_o, in request order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write blink period, turn color and brake
//   color; write them only while no pixel is in flight.
// Pipeline and throughput:
//   A pixel passes through one decode stage, eight remainder stages
//   retiring four bits of the 32-bit elapsed time each, and two shading
//   stages. One request is accepted per cycle while the output is not
//   stalled.
// Reset:
//   All stages empty, start time zero, period 700 ms, turn 0xFF8000,
//   brake 0xFF0000.
// Stall:
//   Every stage holds its own valid bit and loads when empty or when its
//   successor moves, so input stays ready until the pipeline is full.
// ----------------------------------------------------------------------------
module sequential_turn_arrow_pixel_top import stp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  stp_pix_if.sink               pix_i,
  stp_rgb_if.source             rgb_o
);

  cfg_t   cfg;
  logic   ent_valid;
  logic   ent_ready;
  entry_t ent_data;
  logic   mod_valid;
  logic   mod_ready;
  phase_t mod_data;

  stp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  stp_entry u_entry (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_data_i   (pix_i.payload),
    .out_valid_o (ent_valid),
    .out_ready_i (ent_ready),
    .out_data_o  (ent_data)
  );

  stp_mod u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (cfg.blink_period_ms),
    .in_valid_i  (ent_valid),
    .in_ready_o  (ent_ready),
    .in_data_i   (ent_data),
    .out_valid_o (mod_valid),
    .out_ready_i (mod_ready),
    .out_data_o  (mod_data)
  );

  stp_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (mod_valid),
    .in_ready_o  (mod_ready),
    .in_data_i   (mod_data),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_data_o  (rgb_o.payload)
  );

endmodule

// File: design/stp_checker.sv
// ----------------------------------------------------------------------------
// stp_checker: port-level assertions for the turn arrow pixel generator
// Output handshake behavior, ready propagation and reset state.
// ----------------------------------------------------------------------------
module stp_checker import stp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic pix_ready_i,
  input logic rgb_valid_i,
  input logic rgb_ready_i,
  input rgb_t rgb_data_i
);

  // A stalled result stays offered
  a_rgb_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_valid_i && !rgb_ready_i |=> rgb_valid_i)
    else $error("rgb valid dropped while stalled");

  // A stalled result keeps its color
  a_rgb_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_valid_i && !rgb_ready_i |=> $stable(rgb_data_i))
    else $error("rgb payload changed while stalled");

  // With the sink ready every stage can advance, so input is ready too
  a_ready_chain: assert property (@(posedge clk_i)
    rgb_ready_i |-> pix_ready_i)
    else $error("input not ready while output is ready");

  // Reset empties the pipeline by the following edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !rgb_valid_i)
    else $error("rgb valid after reset");

endmodule

bind sequential_turn_arrow_pixel_top stp_checker u_stp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pix_i.ready),
  .rgb_valid_i (rgb_o.valid),
  .rgb_ready_i (rgb_o.ready),
  .rgb_data_i  (rgb_o.payload)
);

// File: verif/tb_sequential_turn_arrow_pixel_top.sv
// ----------------------------------------------------------------------------
// tb_sequential_turn_arrow_pixel_top: pixel generator self-checking bench
// Drives start and pixel requests with random source gaps and sink stalls.
// A behavioral shading model predicts the color of every pixel, and each
// color transaction is compared per channel against the oldest prediction.
// Directed tests cover reset values, segment geometry, brake-turn, blink
// phase edges and register saturation. Random traffic follows with mostly
// well-formed start/pixel sequences mixed with noise requests.
// ----------------------------------------------------------------------------
module tb_sequential_turn_arrow_pixel_top import stp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 8;
  localparam int          MAX_IDLE     = 11;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          DRAIN_LIMIT  = 4000;
  localparam int          RAND_PHASES  = 10;
  localparam int          PHASE_ITEMS  = 105;
  localparam int          MAX_REPORTS  = 40;
  localparam int          TIMEOUT_NS   = 5_000_000;
  localparam logic [SEG_W-1:0] SEG_NONE = 2'd3;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  stp_pix_if pix_if ();
  stp_rgb_if rgb_if ();

  sequential_turn_arrow_pixel_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .rgb_o      (rgb_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the block state, updated at each accepted transaction
  int unsigned       period_ms = PERIOD_RESET;
  rgb_t              turn_rgb  = TURN_RESET;
  rgb_t              brake_rgb = BRAKE_RESET;
  logic [TIME_W-1:0] anim_start = '0;

  rgb_t expected_rgb_q[$];

  bit src_idle_en  = 1'b1;
  bit snk_stall_en = 1'b1;

  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned pixels_sent  = 0;
  int unsigned starts_sent  = 0;
  int unsigned reg_writes   = 0;

  // Color of one pixel under the current shadow state
  function automatic rgb_t shade_pixel(pix_req_t req);
    int unsigned       h, w, row, col, half, phase, front, travel, wing, dr;
    logic [TIME_W-1:0] elapsed;
    rgb_t              black;
    black = '0;
    if (req.segment == SEG_NONE) return black;
    h   = (req.segment == SEG_PANEL) ? MAIN_HEIGHT : STRIP_HEIGHT;
    w   = (req.segment == SEG_PANEL) ? MAIN_WIDTH : STRIP_WIDTH;
    row = req.row;
    col = req.col;
    if (row >= h || col >= w) return black;
    // brake-turn holds main and bottom steady
    if (req.braking && req.segment != SEG_TOP) return brake_rgb;
    half    = period_ms / 2;
    elapsed = req.now_ms - anim_start;
    phase   = elapsed % period_ms;
    if (phase >= half) return black;
    front  = phase * FRONT_SPAN / half;
    travel = (w - 1 - col) * TRAVEL_SPAN / (w - 1);
    dr     = (2 * row >= h - 1) ? (2 * row - (h - 1)) : ((h - 1) - 2 * row);
    wing   = dr * WING_SPAN / (h - 1);
    return (travel + wing <= front) ? turn_rgb : black;
  endfunction

  function automatic pix_req_t make_req(logic op, logic [SEG_W-1:0] seg,
                                        logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                        logic [TIME_W-1:0] now, logic brake);
    pix_req_t req;
    req.opcode  = op;
    req.segment = seg;
    req.row     = row;
    req.col     = col;
    req.now_ms  = now;
    req.braking = brake;
    return req;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h (result %0d)",
               $time, what, got, want, results_seen);
  endtask

  // Send one request; valid stays high when the next one follows at once
  task automatic send_item(pix_req_t req);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.payload <= req;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    if (req.opcode == OPC_START) begin
      anim_start = req.now_ms;
      starts_sent++;
    end else begin
      expected_rgb_q.push_back(shade_pixel(req));
      pixels_sent++;
    end
  endtask

  // Let every pixel in flight come out, then cover trailing start requests
  task automatic wait_drain();
    int unsigned guard;
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    for (guard = 0; expected_rgb_q.size() != 0 && guard < DRAIN_LIMIT; guard++)
      @(posedge clk_i);
    if (expected_rgb_q.size() != 0) begin
      report_mismatch("colors never returned", 0, expected_rgb_q.size());
      expected_rgb_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int unsigned v;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLINK_PERIOD: begin
        v = data[PERIOD_W-1:0];
        if (v < PERIOD_MIN) v = PERIOD_MIN;
        if (v > PERIOD_MAX) v = PERIOD_MAX;
        period_ms = v;
      end
      REG_TURN_COLOUR:  turn_rgb  = data;
      REG_BRAKE_COLOUR: brake_rgb = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Compare one color transaction against the oldest prediction
  task automatic check_result(rgb_t got);
    rgb_t want;
    if (expected_rgb_q.size() == 0) begin
      report_mismatch("unexpected color", got, 0);
      return;
    end
    want = expected_rgb_q.pop_front();
    results_seen++;
    if (got.red != want.red)     report_mismatch("red", got.red, want.red);
    if (got.green != want.green) report_mismatch("green", got.green, want.green);
    if (got.blue != want.blue)   report_mismatch("blue", got.blue, want.blue);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rgb_if.valid && rgb_if.ready) check_result(rgb_if.payload);
  end

  // Sink side: random stall before each color transaction
  initial begin : sink_ready
    int unsigned hold;
    rgb_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = snk_stall_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold != 0) begin
        rgb_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rgb_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rgb_if.valid) @(posedge clk_i);
    end
  end

  // Default registers, start time zero after reset
  task automatic test_reset_defaults();
    send_item(make_req(OPC_PIXEL, SEG_TOP, 0, 15, 32'd349, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 0, 0, 32'd0, 1'b1));
  endtask

  // Segment code three, out-of-range positions and corners
  task automatic test_segment_edges();
    send_item(make_req(OPC_PIXEL, SEG_NONE, 0, 0, 32'd100, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_NONE, 63, 63, 32'd100, 1'b1));
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 7, 15, 32'd100, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 8, 0, 32'd100, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 0, 16, 32'd100, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_TOP, 3, 0, 32'd100, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_BOTTOM, 4, 15, 32'd100, 1'b0));
  endtask

  // Brake-turn: steady brake color on main and bottom, sweep on top
  task automatic test_brake_turn();
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 3, 7, 32'd100, 1'b1));
    send_item(make_req(OPC_PIXEL, SEG_BOTTOM, 0, 0, 32'd100, 1'b1));
    send_item(make_req(OPC_PIXEL, SEG_TOP, 0, 15, 32'd100, 1'b1));
    send_item(make_req(OPC_PIXEL, SEG_BOTTOM, 4, 0, 32'd500, 1'b1));
  endtask

  // Half-period boundary, period wrap and 32-bit elapsed wrap
  task automatic test_phase_edges();
    send_item(make_req(OPC_START, SEG_NONE, 63, 63, 32'hFFFF_FF00, 1'b1));
    send_item(make_req(OPC_PIXEL, SEG_TOP, 1, 15, 32'h0000_005B, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_TOP, 1, 15, 32'h0000_005E, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_TOP, 1, 15, 32'h0000_01BB, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_TOP, 1, 15, 32'hFFFF_FFFF, 1'b0));
    send_item(make_req(OPC_START, SEG_PANEL, 0, 0, 32'h0000_0000, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 3, 15, 32'h0000_0000, 1'b0));
  endtask

  // Lit pixel just before the half period, plus one brake pixel
  task automatic probe_setting();
    send_item(make_req(OPC_PIXEL, SEG_TOP, 1, 15, anim_start + period_ms / 2 - 1, 1'b0));
    send_item(make_req(OPC_PIXEL, SEG_PANEL, 0, 0, anim_start, 1'b1));
  endtask

  // Period saturation at both ends and extreme colors
  task automatic test_register_extremes();
    wait_drain();
    write_reg(REG_BLINK_PERIOD, 24'h000000);
    write_reg(REG_TURN_COLOUR, 24'h000000);
    probe_setting();
    wait_drain();
    write_reg(REG_BLINK_PERIOD, 24'd201);
    write_reg(REG_BRAKE_COLOUR, 24'hFFFFFF);
    probe_setting();
    wait_drain();
    write_reg(REG_BLINK_PERIOD, 24'd1500);
    write_reg(REG_TURN_COLOUR, 24'hFFFFFF);
    probe_setting();
    wait_drain();
    write_reg(REG_BLINK_PERIOD, 24'd1501);
    write_reg(REG_BRAKE_COLOUR, 24'h000000);
    probe_setting();
    wait_drain();
    write_reg(REG_BLINK_PERIOD, 24'h000800);
    write_reg(REG_TURN_COLOUR, 24'h5AA5C3);
    probe_setting();
  endtask

  // Phases of random settings; each a start followed by pixels near it
  task automatic test_random_traffic();
    int unsigned       n, k, roll, h, w;
    logic [SEG_W-1:0]  seg;
    logic [TIME_W-1:0] now;
    for (n = 0; n < RAND_PHASES; n++) begin
      wait_drain();
      src_idle_en  = ($urandom_range(0, 3) != 0);
      snk_stall_en = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_BLINK_PERIOD, 24'd199);
          1:       write_reg(REG_BLINK_PERIOD, 24'd200);
          2:       write_reg(REG_BLINK_PERIOD, 24'd2047);
          default: write_reg(REG_BLINK_PERIOD, 24'hFFFFFF);
        endcase
      end else if (roll == 2) begin
        write_reg(REG_BLINK_PERIOD, 24'($urandom));
      end else begin
        write_reg(REG_BLINK_PERIOD, 24'($urandom_range(PERIOD_MIN, PERIOD_MAX)));
      end
      write_reg(REG_TURN_COLOUR, ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom));
      write_reg(REG_BRAKE_COLOUR, ($urandom_range(0, 7) == 0) ? 24'h000000 : 24'($urandom));
      send_item(make_req(OPC_START, 2'($urandom), 6'($urandom), 6'($urandom),
                         $urandom, 1'($urandom)));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 86) begin
          seg = 2'($urandom_range(0, 2));
          h   = (seg == SEG_PANEL) ? MAIN_HEIGHT : STRIP_HEIGHT;
          w   = (seg == SEG_PANEL) ? MAIN_WIDTH : STRIP_WIDTH;
          now = anim_start + TIME_W'($urandom_range(0, 3 * period_ms - 1));
          send_item(make_req(OPC_PIXEL, seg, 6'($urandom_range(0, h - 1)),
                             6'($urandom_range(0, w - 1)), now,
                             ($urandom_range(0, 3) == 0)));
        end else if (roll < 90) begin
          send_item(make_req(OPC_START, SEG_PANEL, 0, 0, $urandom, 1'b0));
        end else begin
          // noise: any field value, including absent segments and pixels
          send_item(make_req(1'($urandom), 2'($urandom), 6'($urandom), 6'($urandom),
                             $urandom, 1'($urandom)));
        end
      end
    end
  endtask

  initial begin : main_seq
    pix_if.valid   <= 1'b0;
    pix_if.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_segment_edges();
    test_brake_turn();
    test_phase_edges();
    test_register_extremes();
    test_random_traffic();
    wait_drain();

    $display("Covered %0d pixel and %0d start transactions, %0d register writes",
             pixels_sent, starts_sent, reg_writes);
    $display("Checked %0d colors, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the pipeline hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d colors outstanding", expected_rgb_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
